[rtl/uled_pkg.sv]
`timescale 1ns / 1ps
// Package for the line editor with echo: key codes, command and status structs,
// controller states. Used by all modules of the block; has no dependencies.
package uled_pkg;

   localparam int ULED_LINE_CAPACITY = 64;

   localparam logic [7:0] KEY_CR     = 8'd13;
   localparam logic [7:0] KEY_LF     = 8'd10;
   localparam logic [7:0] KEY_BS     = 8'd8;
   localparam logic [7:0] KEY_DEL    = 8'd127;
   localparam logic [7:0] KEY_SPACE  = 8'd32;
   localparam logic [7:0] PRINT_LOW  = 8'd32;
   localparam logic [7:0] PRINT_HIGH = 8'd126;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ECHO,
      ST_READ_ADDR,
      ST_READ_DATA
   } uled_state_type;

   typedef enum logic [1:0] {
      ECHO_CHAR,
      ECHO_NEWLINE,
      ECHO_ERASE
   } uled_echo_type;

   typedef enum logic [2:0] {
      LINE_NONE,
      LINE_APPEND,
      LINE_ERASE,
      LINE_DISCARD,
      LINE_CLOSE,
      LINE_CLEAR
   } uled_line_op_type;

   typedef enum logic [2:0] {
      OUT_RX,
      OUT_CR,
      OUT_LF,
      OUT_BS,
      OUT_SP,
      OUT_MEM
   } uled_out_sel_type;

   typedef struct packed {
      logic             capture;
      uled_line_op_type line_op;
      logic             rd_start;
      logic             rd_en;
      logic             rd_advance;
      logic             load_out;
      uled_out_sel_type out_sel;
      logic             out_last;
   } uled_cmd_type;

   typedef struct packed {
      logic is_take;
      logic is_enter;
      logic is_erase;
      logic is_print;
      logic line_empty;
      logic line_full;
      logic line_pending;
      logic out_free;
      logic rd_last;
   } uled_status_type;

endpackage

[rtl/uart_line_editor_echo.sv]
`timescale 1ns / 1ps
// Top level of the terminal line editor with echo: ties the controller to the
// datapath. Depends on uled_pkg, uled_control and uled_datapath.
//
// Requests carry either a received byte (req_tuser = 0) or a take command
// (req_tuser = 1). One request is handled at a time. An accepted byte request
// is followed by its echo bytes (1 for a character, 2 for CR LF, 3 for an
// erase), each loaded when the result register is free; an ignored byte gets
// no echo. A take request reads the line out through the single registered
// read port of the line store, an address state and a data state per line
// character. Results leave through a one-entry output register. The line
// store needs no clearing after reset; the block accepts requests at once.
module uart_line_editor_echo
   import uled_pkg::*;
#(
   parameter int LINE_CAPACITY = ULED_LINE_CAPACITY
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] rx_byte
   input  logic [0:0] req_tuser,   // [0] command
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [0:0] rsp_tuser,   // [0] out_kind
   output logic       rsp_tlast
);

   uled_cmd_type    cmd;
   uled_status_type status;

   uled_control u_control (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   uled_datapath #(
      .LINE_CAPACITY (LINE_CAPACITY)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .cmd        (cmd),
      .status     (status)
   );

endmodule

[rtl/uled_datapath.sv]
`timescale 1ns / 1ps
// Datapath of the line editor: line store memory, length and pending flags,
// read-out index and the result register. Depends on uled_pkg.
module uled_datapath
   import uled_pkg::*;
#(
   parameter int LINE_CAPACITY = ULED_LINE_CAPACITY
) (
   input  logic            clock,
   input  logic            reset,
   input  logic [7:0]      req_tdata,
   input  logic [0:0]      req_tuser,
   output logic            rsp_tvalid,
   input  logic            rsp_tready,
   output logic [7:0]      rsp_tdata,
   output logic [0:0]      rsp_tuser,
   output logic            rsp_tlast,
   input  uled_cmd_type    cmd,
   output uled_status_type status
);

   localparam int LEN_W = $clog2(LINE_CAPACITY);

   logic [6:0]       line_mem [LINE_CAPACITY];
   logic [6:0]       rd_data_ff;
   logic [LEN_W-1:0] line_length_ff, line_length_in;
   logic             line_pending_ff, line_pending_in;
   logic [LEN_W-1:0] rd_idx_ff, rd_idx_in;
   logic [LEN_W-1:0] rd_idx_next;
   logic [7:0]       byte_ff;
   logic             out_valid_ff, out_valid_in;
   logic [7:0]       out_byte_ff;
   logic             out_kind_ff;
   logic             out_last_ff;
   logic [7:0]       out_byte_sel;

   // Decode the incoming request and report line and result state
   always_comb begin
      status.is_take      = req_tuser[0];
      status.is_enter     = (req_tdata == KEY_CR) || (req_tdata == KEY_LF);
      status.is_erase     = (req_tdata == KEY_BS) || (req_tdata == KEY_DEL);
      status.is_print     = (req_tdata >= PRINT_LOW) && (req_tdata <= PRINT_HIGH);
      status.line_empty   = (line_length_ff == '0);
      status.line_full    = (line_length_ff == LEN_W'(LINE_CAPACITY - 1));
      status.line_pending = line_pending_ff;
      status.out_free     = !out_valid_ff || rsp_tready;
      status.rd_last      = (rd_idx_next == line_length_ff);
   end

   assign rd_idx_next = rd_idx_ff + 1'b1;

   always_comb begin
      line_length_in  = line_length_ff;
      line_pending_in = line_pending_ff;
      unique case (cmd.line_op)
         LINE_NONE:    ;
         LINE_APPEND:  line_length_in = line_length_ff + 1'b1;
         LINE_ERASE:   line_length_in = line_length_ff - 1'b1;
         LINE_DISCARD: line_length_in = '0;
         LINE_CLOSE:   line_pending_in = 1'b1;
         LINE_CLEAR: begin
            line_length_in  = '0;
            line_pending_in = 1'b0;
         end
         default:      ;
      endcase
   end

   always_comb begin
      rd_idx_in = rd_idx_ff;
      if (cmd.rd_start) begin
         rd_idx_in = '0;
      end else if (cmd.rd_advance) begin
         rd_idx_in = rd_idx_next;
      end
   end

   always_comb begin
      unique case (cmd.out_sel)
         OUT_RX:  out_byte_sel = byte_ff;
         OUT_CR:  out_byte_sel = KEY_CR;
         OUT_LF:  out_byte_sel = KEY_LF;
         OUT_BS:  out_byte_sel = KEY_BS;
         OUT_SP:  out_byte_sel = KEY_SPACE;
         OUT_MEM: out_byte_sel = {1'b0, rd_data_ff};
         default: out_byte_sel = byte_ff;
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.load_out) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.line_op == LINE_APPEND) begin
         line_mem[line_length_ff] <= req_tdata[6:0];
      end
      if (cmd.rd_en) begin
         rd_data_ff <= line_mem[rd_idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_length_ff  <= '0;
         line_pending_ff <= 1'b0;
         out_valid_ff    <= 1'b0;
      end else begin
         line_length_ff  <= line_length_in;
         line_pending_ff <= line_pending_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_idx_in;
      if (cmd.capture) begin
         byte_ff <= req_tdata;
      end
      if (cmd.load_out) begin
         out_byte_ff <= out_byte_sel;
         out_kind_ff <= (cmd.out_sel == OUT_MEM);
         out_last_ff <= cmd.out_last;
      end
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = out_byte_ff;
   assign rsp_tuser[0] = out_kind_ff;
   assign rsp_tlast    = out_last_ff;

   a_pending_nonempty: assert property (@(posedge clock) disable iff (reset)
      line_pending_ff |-> (line_length_ff != '0))
      else $error("pending line with zero length");

   a_length_bound: assert property (@(posedge clock) disable iff (reset)
      32'(line_length_ff) <= LINE_CAPACITY - 1)
      else $error("line length beyond capacity");

   a_readout_pending: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_out && (cmd.out_sel == OUT_MEM)) |-> line_pending_ff)
      else $error("line character sent without a pending line");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!out_valid_ff || rsp_tready))
      else $error("result register overwritten while full");

endmodule

[rtl/uled_control.sv]
`timescale 1ns / 1ps
// Controller of the line editor: decides the action for each request and
// sequences echo bytes and line read-out. Depends on uled_pkg.
module uled_control
   import uled_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  uled_status_type status,
   output uled_cmd_type    cmd
);

   uled_state_type state_ff, state_in;
   uled_echo_type  echo_ff, echo_in;
   logic [1:0]     step_ff, step_in;
   logic           accept;
   logic           echo_done;

   assign accept = req_tvalid && (state_ff == ST_IDLE);

   always_comb begin
      unique case (echo_ff)
         ECHO_CHAR:    echo_done = 1'b1;
         ECHO_NEWLINE: echo_done = (step_ff == 2'd1);
         ECHO_ERASE:   echo_done = (step_ff == 2'd2);
         default:      echo_done = 1'b1;
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      echo_in  = echo_ff;
      step_in  = step_ff;
      unique case (state_ff)
         ST_IDLE: begin
            step_in = '0;
            if (accept) begin
               priority if (status.is_take) begin
                  if (status.line_pending) begin
                     state_in = ST_READ_ADDR;
                  end
               end else if (status.line_pending) begin
                  state_in = ST_IDLE;
               end else if (status.is_enter && !status.line_empty) begin
                  state_in = ST_ECHO;
                  echo_in  = ECHO_NEWLINE;
               end else if (status.is_erase && !status.line_empty) begin
                  state_in = ST_ECHO;
                  echo_in  = ECHO_ERASE;
               end else if (status.is_print && !status.line_full) begin
                  state_in = ST_ECHO;
                  echo_in  = ECHO_CHAR;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_ECHO: begin
            if (status.out_free) begin
               if (echo_done) begin
                  state_in = ST_IDLE;
               end else begin
                  step_in = step_ff + 1'b1;
               end
            end
         end
         ST_READ_ADDR: state_in = ST_READ_DATA;
         ST_READ_DATA: begin
            if (status.out_free) begin
               state_in = status.rd_last ? ST_IDLE : ST_READ_ADDR;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd            = '0;
      cmd.line_op    = LINE_NONE;
      cmd.out_sel    = OUT_RX;
      req_tready     = (state_ff == ST_IDLE);
      unique case (state_ff)
         ST_IDLE: begin
            cmd.capture = accept;
            if (accept) begin
               priority if (status.is_take) begin
                  cmd.rd_start = status.line_pending;
               end else if (status.line_pending) begin
                  cmd.line_op = LINE_NONE;
               end else if (status.is_enter && !status.line_empty) begin
                  cmd.line_op = LINE_CLOSE;
               end else if (status.is_erase && !status.line_empty) begin
                  cmd.line_op = LINE_ERASE;
               end else if (status.is_print) begin
                  // Drop the whole line when the store is full
                  cmd.line_op = status.line_full ? LINE_DISCARD : LINE_APPEND;
               end else begin
                  cmd.line_op = LINE_NONE;
               end
            end
         end
         ST_ECHO: begin
            cmd.load_out = status.out_free;
            cmd.out_last = echo_done;
            unique case (echo_ff)
               ECHO_CHAR:    cmd.out_sel = OUT_RX;
               ECHO_NEWLINE: cmd.out_sel = (step_ff == 2'd0) ? OUT_CR : OUT_LF;
               ECHO_ERASE:   cmd.out_sel = (step_ff == 2'd1) ? OUT_SP : OUT_BS;
               default:      cmd.out_sel = OUT_RX;
            endcase
         end
         ST_READ_ADDR: cmd.rd_en = 1'b1;
         ST_READ_DATA: begin
            cmd.out_sel    = OUT_MEM;
            cmd.out_last   = status.rd_last;
            cmd.load_out   = status.out_free;
            cmd.rd_advance = status.out_free && !status.rd_last;
            cmd.line_op    = (status.out_free && status.rd_last) ? LINE_CLEAR : LINE_NONE;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         echo_ff  <= ECHO_CHAR;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         echo_ff  <= echo_in;
         step_ff  <= step_in;
      end
   end

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ECHO) |-> (step_ff != 2'd3))
      else $error("echo step out of range");

   a_readout_follows_addr: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ_DATA) |-> ($past(state_ff) == ST_READ_ADDR
                                      || $past(state_ff) == ST_READ_DATA))
      else $error("read data state entered without an address cycle");

   a_take_starts_readout: assert property (@(posedge clock) disable iff (reset)
      (accept && status.is_take && status.line_pending) |=> (state_ff == ST_READ_ADDR))
      else $error("take request did not start line read-out");

endmodule
